### rtl/vector_to_pitch_yaw_core_defines.svh
// Assertion macros used by the vector-to-angles RTL.
`ifndef VECTOR_TO_PITCH_YAW_CORE_DEFINES_SVH
`define VECTOR_TO_PITCH_YAW_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define VTPY_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("vtpy: same-cycle check failed");

// Next-cycle implication, disabled while in reset
`define VTPY_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("vtpy: next-cycle check failed");

`endif

### rtl/vtpy_pkg.sv
// Shared types, widths and constants of the vector-to-angles pipeline.
package vtpy_pkg;

  // Component width and fixed-point layout
  localparam int COMP_BITS = 16;
  localparam int GUARD     = 24;
  localparam int ANG_FRAC  = 20;
  localparam int ANG_W     = 31;
  localparam int DATA_W    = COMP_BITS + GUARD + 4;
  localparam int SQ_W      = 2 * COMP_BITS;
  localparam int ZP_W      = COMP_BITS + 32;
  localparam int DEG_W     = ANG_W - ANG_FRAC;
  localparam int OUT_W     = 9;
  localparam int TAB_LEN   = 24;

  // CORDIC gain in Q30, applied to z before the pitch pass
  localparam logic [31:0] K_Q30     = 32'd1768195363;
  localparam int          KQ_SHIFT  = 30 - GUARD;

  // atan(2^-i) in degrees, Q(ANG_FRAC), rounded
  localparam int ATAN_TAB [0:TAB_LEN-1] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7
  };

  localparam logic signed [ANG_W-1:0] ANG_180 = ANG_W'(180 * (1 << ANG_FRAC));

  // Whole-degree results
  localparam logic [OUT_W-1:0] DEG_0   = 9'd0;
  localparam logic [OUT_W-1:0] DEG_45  = 9'd45;
  localparam logic [OUT_W-1:0] DEG_90  = 9'd90;
  localparam logic [OUT_W-1:0] DEG_135 = 9'd135;
  localparam logic [OUT_W-1:0] DEG_180 = 9'd180;
  localparam logic [OUT_W-1:0] DEG_225 = 9'd225;
  localparam logic [OUT_W-1:0] DEG_270 = 9'd270;
  localparam logic [OUT_W-1:0] DEG_315 = 9'd315;
  localparam logic [OUT_W-1:0] DEG_360 = 9'd360;

  typedef struct packed {
    logic signed [COMP_BITS-1:0] comp_x;
    logic signed [COMP_BITS-1:0] comp_y;
    logic signed [COMP_BITS-1:0] comp_z;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] pitch;
    logic [OUT_W-1:0] yaw;
  } out_item_t;

  // Exact-angle cases, carried alongside the CORDIC data
  typedef struct packed {
    logic xy_zero;
    logic x_zero;
    logic y_zero;
    logic x_pos;
    logic y_pos;
    logic ax_eq_ay;
    logic z_pos;
    logic z_zero;
    logic zh_eq;
  } vtpy_flags_t;

  // Sideband through the yaw pass
  typedef struct packed {
    vtpy_flags_t                flags;
    logic signed [DATA_W-1:0]   zk;
  } vtpy_side1_t;

  // Sideband through the pitch pass
  typedef struct packed {
    vtpy_flags_t                flags;
    logic signed [ANG_W-1:0]    yaw_ang;
  } vtpy_side2_t;

  localparam int SIDE1_W = $bits(vtpy_side1_t);
  localparam int SIDE2_W = $bits(vtpy_side2_t);

endpackage

### rtl/vtpy_prep.sv
// Front end: magnitudes, squares, gain product, exact-case flags, CORDIC start values.
module vtpy_prep import vtpy_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     src_valid,
  input  in_item_t                 src_data,
  output logic                     valid_out,
  output logic signed [DATA_W-1:0] x_out,
  output logic signed [DATA_W-1:0] y_out,
  output logic signed [ANG_W-1:0]  ang_out,
  output vtpy_side1_t              side_out
);

  logic signed [COMP_BITS-1:0] x_s, y_s, z_s;
  logic [COMP_BITS-1:0]        ax, ay, az;
  logic                        x_neg;
  logic signed [DATA_W-1:0]    x_sh, y_sh;

  // First level next values
  vtpy_flags_t                 fl1_nxt;
  logic signed [DATA_W-1:0]    x1_nxt, y1_nxt;
  logic signed [ANG_W-1:0]     ang1_nxt;
  logic [SQ_W-1:0]             axsq1_nxt, aysq1_nxt, azsq1_nxt;
  logic signed [ZP_W-1:0]      zp1_nxt;

  // First level registers
  logic                        v1_r;
  vtpy_flags_t                 fl1_r;
  logic signed [DATA_W-1:0]    x1_r, y1_r;
  logic signed [ANG_W-1:0]     ang1_r;
  logic [SQ_W-1:0]             axsq1_r, aysq1_r, azsq1_r;
  logic signed [ZP_W-1:0]      zp1_r;

  // Second level
  logic [SQ_W:0]               h2;
  vtpy_flags_t                 fl2_nxt;
  logic signed [DATA_W-1:0]    zk2_nxt;
  logic                        v2_r;
  vtpy_flags_t                 fl2_r;
  logic signed [DATA_W-1:0]    x2_r, y2_r, zk2_r;
  logic signed [ANG_W-1:0]     ang2_r;

  assign x_s = src_data.comp_x;
  assign y_s = src_data.comp_y;
  assign z_s = src_data.comp_z;

  // Magnitudes; the most negative value maps to 2^(COMP_BITS-1)
  always_comb begin
    ax = x_s[COMP_BITS-1] ? $unsigned(-x_s) : $unsigned(x_s);
    ay = y_s[COMP_BITS-1] ? $unsigned(-y_s) : $unsigned(y_s);
    az = z_s[COMP_BITS-1] ? $unsigned(-z_s) : $unsigned(z_s);
  end

  // Flags, folded start vector and start angle
  always_comb begin
    x_neg            = x_s[COMP_BITS-1];
    fl1_nxt.x_zero   = (x_s == '0);
    fl1_nxt.y_zero   = (y_s == '0);
    fl1_nxt.xy_zero  = (x_s == '0) && (y_s == '0);
    fl1_nxt.x_pos    = !x_s[COMP_BITS-1] && (x_s != '0);
    fl1_nxt.y_pos    = !y_s[COMP_BITS-1] && (y_s != '0);
    fl1_nxt.ax_eq_ay = (ax == ay);
    fl1_nxt.z_pos    = !z_s[COMP_BITS-1] && (z_s != '0);
    fl1_nxt.z_zero   = (z_s == '0);
    fl1_nxt.zh_eq    = 1'b0;

    x_sh   = DATA_W'(x_s) <<< GUARD;
    y_sh   = DATA_W'(y_s) <<< GUARD;
    x1_nxt = x_neg ? -x_sh : x_sh;
    y1_nxt = x_neg ? -y_sh : y_sh;

    // Left half-plane: rotate by 180 and start the angle there
    if (x_neg) begin
      ang1_nxt = fl1_nxt.y_pos ? ANG_180 : -ANG_180;
    end else begin
      ang1_nxt = '0;
    end

    axsq1_nxt = SQ_W'(ax) * SQ_W'(ax);
    aysq1_nxt = SQ_W'(ay) * SQ_W'(ay);
    azsq1_nxt = SQ_W'(az) * SQ_W'(az);
    zp1_nxt   = ZP_W'(z_s) * ZP_W'($signed(K_Q30));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= src_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fl1_r   <= fl1_nxt;
      x1_r    <= x1_nxt;
      y1_r    <= y1_nxt;
      ang1_r  <= ang1_nxt;
      axsq1_r <= axsq1_nxt;
      aysq1_r <= aysq1_nxt;
      azsq1_r <= azsq1_nxt;
      zp1_r   <= zp1_nxt;
    end
  end

  // z^2 against x^2 + y^2, and z scaled by the gain
  always_comb begin
    h2            = {1'b0, axsq1_r} + {1'b0, aysq1_r};
    fl2_nxt       = fl1_r;
    fl2_nxt.zh_eq = (h2 == {1'b0, azsq1_r});
    zk2_nxt       = DATA_W'(zp1_r >>> KQ_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fl2_r  <= fl2_nxt;
      x2_r   <= x1_r;
      y2_r   <= y1_r;
      ang2_r <= ang1_r;
      zk2_r  <= zk2_nxt;
    end
  end

  assign valid_out      = v2_r;
  assign x_out          = x2_r;
  assign y_out          = y2_r;
  assign ang_out        = ang2_r;
  assign side_out.flags = fl2_r;
  assign side_out.zk    = zk2_r;

endmodule

### rtl/vtpy_cordic_stage.sv
// One registered CORDIC vectoring iteration with a pass-through sideband.
module vtpy_cordic_stage import vtpy_pkg::*; #(
  parameter int STAGE  = 0,
  parameter int SIDE_W = 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     valid_in,
  input  logic signed [DATA_W-1:0] x_in,
  input  logic signed [DATA_W-1:0] y_in,
  input  logic signed [ANG_W-1:0]  ang_in,
  input  logic [SIDE_W-1:0]        side_in,
  output logic                     valid_out,
  output logic signed [DATA_W-1:0] x_out,
  output logic signed [DATA_W-1:0] y_out,
  output logic signed [ANG_W-1:0]  ang_out,
  output logic [SIDE_W-1:0]        side_out
);

  localparam logic signed [ANG_W-1:0] STEP_ANG = ANG_W'(ATAN_TAB[STAGE]);

  logic                     y_nonneg;
  logic signed [DATA_W-1:0] dx, dy;
  logic signed [DATA_W-1:0] x_nxt, y_nxt;
  logic signed [ANG_W-1:0]  ang_nxt;

  logic                     valid_r;
  logic signed [DATA_W-1:0] x_r, y_r;
  logic signed [ANG_W-1:0]  ang_r;
  logic [SIDE_W-1:0]        side_r;

  // Rotate toward the x axis; shifts floor toward minus infinity
  always_comb begin
    y_nonneg = !y_in[DATA_W-1];
    dx       = y_in >>> STAGE;
    dy       = x_in >>> STAGE;
    if (y_nonneg) begin
      x_nxt   = x_in + dx;
      y_nxt   = y_in - dy;
      ang_nxt = ang_in + STEP_ANG;
    end else begin
      x_nxt   = x_in - dx;
      y_nxt   = y_in + dy;
      ang_nxt = ang_in - STEP_ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      ang_r  <= ang_nxt;
      side_r <= side_in;
    end
  end

  assign valid_out = valid_r;
  assign x_out     = x_r;
  assign y_out     = y_r;
  assign ang_out   = ang_r;
  assign side_out  = side_r;

endmodule

### rtl/vtpy_out.sv
// Back end: degree conversion, exact-angle overrides, output register and skid entry.
`include "vector_to_pitch_yaw_core_defines.svh"

module vtpy_out import vtpy_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    res_valid,
  input  logic signed [ANG_W-1:0] res_pitch_ang,
  input  vtpy_side2_t             res_side,
  output logic                    pipe_en,
  output logic                    out_valid,
  input  logic                    out_ready,
  output out_item_t               out_data
);

  // Truncate toward zero to whole degrees, wrap negatives into 0..359
  function automatic logic [OUT_W-1:0] to_deg(input logic signed [ANG_W-1:0] a);
    logic [ANG_W-1:0] mag;
    logic [DEG_W-1:0] q;
    logic [DEG_W-1:0] d;
    mag = a[ANG_W-1] ? $unsigned(-a) : $unsigned(a);
    q   = mag[ANG_W-1:ANG_FRAC];
    if (a[ANG_W-1] && (q != '0)) begin
      d = DEG_W'(DEG_360) - q;
    end else begin
      d = q;
    end
    return d[OUT_W-1:0];
  endfunction

  vtpy_flags_t fl;
  out_item_t   res;

  out_item_t   out_r, out_nxt;
  logic        out_v_r, out_v_nxt;
  out_item_t   skid_r, skid_nxt;
  logic        skid_v_r, skid_v_nxt;

  logic        park_chk;
  logic        range_ok;

  // Result fields with exact whole-degree cases substituted
  always_comb begin
    fl = res_side.flags;

    if (fl.xy_zero) begin
      res.yaw = DEG_0;
    end else if (fl.y_zero) begin
      res.yaw = fl.x_pos ? DEG_0 : DEG_180;
    end else if (fl.x_zero) begin
      res.yaw = fl.y_pos ? DEG_90 : DEG_270;
    end else if (fl.ax_eq_ay) begin
      if (fl.x_pos) begin
        res.yaw = fl.y_pos ? DEG_45 : DEG_315;
      end else begin
        res.yaw = fl.y_pos ? DEG_135 : DEG_225;
      end
    end else begin
      res.yaw = to_deg(res_side.yaw_ang);
    end

    if (fl.xy_zero) begin
      res.pitch = fl.z_pos ? DEG_90 : DEG_270;
    end else if (fl.z_zero) begin
      res.pitch = DEG_0;
    end else if (fl.zh_eq) begin
      res.pitch = fl.z_pos ? DEG_45 : DEG_315;
    end else begin
      res.pitch = to_deg(res_pitch_ang);
    end
  end

  // Output register plus one skid entry; the pipeline moves while the skid is empty
  always_comb begin
    out_nxt    = out_r;
    out_v_nxt  = out_v_r;
    skid_nxt   = skid_r;
    skid_v_nxt = skid_v_r;
    if (skid_v_r) begin
      if (out_ready) begin
        out_nxt    = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else if (res_valid) begin
      if (!out_v_r || out_ready) begin
        out_nxt   = res;
        out_v_nxt = 1'b1;
      end else begin
        skid_nxt   = res;
        skid_v_nxt = 1'b1;
      end
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign pipe_en   = !skid_v_r;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // Check operands
  assign park_chk = !skid_v_r && res_valid && out_v_r && !out_ready;
  assign range_ok = (out_r.pitch < DEG_360) && (out_r.yaw < DEG_360);

  // A parked item always sits behind a shown one
  `VTPY_ASSERT_IMPL(a_skid_behind_out, clk, rst_n, skid_v_r, out_v_r)
  // A new item arriving at a blocked output goes to the skid entry
  `VTPY_ASSERT_NEXT(a_stall_parks, clk, rst_n, park_chk, skid_v_r)
  // Both angles stay in whole-degree range
  `VTPY_ASSERT_IMPL(a_deg_range, clk, rst_n, out_v_r, range_ok)

endmodule

### rtl/vector_to_pitch_yaw_core.sv
// Path from input acceptance to out_valid: two front-end stages, two chains of CORDIC_STAGES
//   CORDIC stages (yaw pass, then pitch pass) and one output register.
// Throughput: one item per cycle while the skid entry is empty (in_ready high).
// An output register with a one-entry skid keeps in_ready high while one result waits.
// Reset (rst_n low, synchronous) clears the valid bits and empties the output side.
module vector_to_pitch_yaw_core import vtpy_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic pipe_en;

  // Yaw pass taps
  logic                     p1_v    [0:CORDIC_STAGES];
  logic signed [DATA_W-1:0] p1_x    [0:CORDIC_STAGES];
  logic signed [DATA_W-1:0] p1_y    [0:CORDIC_STAGES];
  logic signed [ANG_W-1:0]  p1_ang  [0:CORDIC_STAGES];
  logic [SIDE1_W-1:0]       p1_side [0:CORDIC_STAGES];

  // Pitch pass taps
  logic                     p2_v    [0:CORDIC_STAGES];
  logic signed [DATA_W-1:0] p2_x    [0:CORDIC_STAGES];
  logic signed [DATA_W-1:0] p2_y    [0:CORDIC_STAGES];
  logic signed [ANG_W-1:0]  p2_ang  [0:CORDIC_STAGES];
  logic [SIDE2_W-1:0]       p2_side [0:CORDIC_STAGES];

  vtpy_side1_t prep_side;
  vtpy_side1_t p1_end;
  vtpy_side2_t p2_start;

  assign in_ready = pipe_en;

  vtpy_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .src_valid (in_valid),
    .src_data  (in_data),
    .valid_out (p1_v[0]),
    .x_out     (p1_x[0]),
    .y_out     (p1_y[0]),
    .ang_out   (p1_ang[0]),
    .side_out  (prep_side)
  );

  assign p1_side[0] = prep_side;

  // Yaw pass: atan2(y, x) from the folded right half-plane vector
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_yaw
    vtpy_cordic_stage #(
      .STAGE  (g),
      .SIDE_W (SIDE1_W)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (pipe_en),
      .valid_in  (p1_v[g]),
      .x_in      (p1_x[g]),
      .y_in      (p1_y[g]),
      .ang_in    (p1_ang[g]),
      .side_in   (p1_side[g]),
      .valid_out (p1_v[g+1]),
      .x_out     (p1_x[g+1]),
      .y_out     (p1_y[g+1]),
      .ang_out   (p1_ang[g+1]),
      .side_out  (p1_side[g+1])
    );
  end

  // Hand-over: gained horizontal length against gain-scaled z
  always_comb begin
    p1_end           = vtpy_side1_t'(p1_side[CORDIC_STAGES]);
    p2_start.flags   = p1_end.flags;
    p2_start.yaw_ang = p1_ang[CORDIC_STAGES];
  end

  assign p2_v[0]    = p1_v[CORDIC_STAGES];
  assign p2_x[0]    = p1_x[CORDIC_STAGES];
  assign p2_y[0]    = p1_end.zk;
  assign p2_ang[0]  = '0;
  assign p2_side[0] = p2_start;

  // Pitch pass
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_pitch
    vtpy_cordic_stage #(
      .STAGE  (g),
      .SIDE_W (SIDE2_W)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (pipe_en),
      .valid_in  (p2_v[g]),
      .x_in      (p2_x[g]),
      .y_in      (p2_y[g]),
      .ang_in    (p2_ang[g]),
      .side_in   (p2_side[g]),
      .valid_out (p2_v[g+1]),
      .x_out     (p2_x[g+1]),
      .y_out     (p2_y[g+1]),
      .ang_out   (p2_ang[g+1]),
      .side_out  (p2_side[g+1])
    );
  end

  vtpy_out u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (p2_v[CORDIC_STAGES]),
    .res_pitch_ang (p2_ang[CORDIC_STAGES]),
    .res_side      (vtpy_side2_t'(p2_side[CORDIC_STAGES])),
    .pipe_en       (pipe_en),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data)
  );

endmodule

### sim/tb_vector_to_pitch_yaw_core.sv
// Self-checking testbench for the vector-to-pitch/yaw CORDIC pipeline.
module tb_vector_to_pitch_yaw_core import vtpy_pkg::*; ();

  localparam int     CORDIC_STAGES = 16;
  localparam int     ATAN_LEN      = 24;
  localparam int     FRAC_BITS     = 20;
  localparam int     GUARD_BITS    = 24;
  localparam longint ONE_DEG       = 64'sd1 <<< FRAC_BITS;
  localparam longint GAIN_Q30      = 64'sd1768195363;
  localparam int     RANDOM_ITEMS  = 1200;
  localparam int     DRAIN_CYCLES  = 2 * CORDIC_STAGES + 20;
  localparam int     CYCLE_LIMIT   = 100000;
  localparam int     QUIET_FROM    = 400;
  localparam int     QUIET_TO      = 900;

  // atan(2^-i) in degrees, Q20
  localparam longint ATAN_Q20 [0:ATAN_LEN-1] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7
  };

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  in_item_t  vectors_pending [$];
  out_item_t angles_due [$];
  logic      in_taken;
  int        cycle_count;
  int        mismatches;

  vector_to_pitch_yaw_core #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // One vectoring pass: returns the angle, leaves gain * length in len
  function automatic longint cordic_vectoring(inout longint len, input longint yv);
    longint xv;
    longint ang;
    longint dx;
    longint dy;
    int     i;
    xv  = len;
    ang = 0;
    for (i = 0; i < CORDIC_STAGES && i < ATAN_LEN; i++) begin
      dx = yv >>> i;
      dy = xv >>> i;
      if (yv >= 0) begin
        xv  += dx;
        yv  -= dy;
        ang += ATAN_Q20[i];
      end else begin
        xv  -= dx;
        yv  += dy;
        ang -= ATAN_Q20[i];
      end
    end
    len = xv;
    return ang;
  endfunction

  // Truncate toward zero, wrap negatives into 0..359
  function automatic logic [OUT_W-1:0] whole_degrees(longint a);
    longint d;
    if (a >= 0) begin
      d = a >>> FRAC_BITS;
    end else begin
      d = -((-a) >>> FRAC_BITS);
    end
    if (d < 0) d += 360;
    return d[OUT_W-1:0];
  endfunction

  // Expected yaw and pitch of one vector
  function automatic out_item_t predict_angles(in_item_t v);
    out_item_t r;
    longint    x, y, z, ax, ay, az;
    longint    cx, cy, fwd, yaw_a, pitch_a, zk, h2, z2;
    x  = $signed(v.comp_x);
    y  = $signed(v.comp_y);
    z  = $signed(v.comp_z);
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    az = (z < 0) ? -z : z;

    // No horizontal length: straight up or down
    if (x == 0 && y == 0) begin
      r.pitch = (z > 0) ? OUT_W'(90) : OUT_W'(270);
      r.yaw   = '0;
      return r;
    end

    // Yaw pass, folded into the right half plane
    cx = x <<< GUARD_BITS;
    cy = y <<< GUARD_BITS;
    if (x < 0) begin
      cx = -cx;
      cy = -cy;
    end
    fwd   = cx;
    yaw_a = cordic_vectoring(fwd, cy);
    if (x < 0) yaw_a += (y > 0) ? 180 * ONE_DEG : -180 * ONE_DEG;

    // Exact yaw on the axes and diagonals
    if (y == 0) begin
      yaw_a = (x > 0) ? 0 : 180 * ONE_DEG;
    end else if (x == 0) begin
      yaw_a = (y > 0) ? 90 * ONE_DEG : -90 * ONE_DEG;
    end else if (ax == ay) begin
      yaw_a = (x > 0 ? 45 : 135) * ONE_DEG * (y > 0 ? 1 : -1);
    end

    // Pitch pass against the gain-scaled horizontal length
    h2 = ax * ax + ay * ay;
    z2 = az * az;
    if (z == 0) begin
      pitch_a = 0;
    end else if (z2 == h2) begin
      pitch_a = (z > 0) ? 45 * ONE_DEG : -45 * ONE_DEG;
    end else begin
      zk      = (z * GAIN_Q30) >>> (30 - GUARD_BITS);
      pitch_a = cordic_vectoring(fwd, zk);
    end

    r.pitch = whole_degrees(pitch_a);
    r.yaw   = whole_degrees(yaw_a);
    return r;
  endfunction

  function automatic logic take_gap();
    if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) return 1'b0;
    return $urandom_range(0, 99) < 24;
  endfunction

  task automatic add_vector(input int x, input int y, input int z);
    in_item_t v;
    v.comp_x = x[COMP_BITS-1:0];
    v.comp_y = y[COMP_BITS-1:0];
    v.comp_z = z[COMP_BITS-1:0];
    vectors_pending.push_back(v);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    mismatches++;
  endtask

  // Random vector, mostly well-spread, some aimed at the exact-angle cases
  task automatic add_random_vector();
    int x, y, z, a, b, c, k, t;
    case ($urandom_range(0, 9))
      5: begin
        x = int'($urandom_range(0, 8)) - 4;
        y = int'($urandom_range(0, 8)) - 4;
        z = int'($urandom_range(0, 8)) - 4;
      end
      6: begin
        x = $signed(16'($urandom));
        y = $signed(16'($urandom));
        z = $signed(16'($urandom));
        if ($urandom_range(0, 1)) x = 0;
        else y = 0;
      end
      7: begin
        a = $urandom_range(1, 32767);
        x = $urandom_range(0, 1) ? -a : a;
        y = $urandom_range(0, 1) ? -a : a;
        z = $signed(16'($urandom));
      end
      8: begin
        // Pythagorean triple: z*z equals x*x + y*y
        case ($urandom_range(0, 3))
          0: begin a = 3; b = 4;  c = 5;  end
          1: begin a = 5; b = 12; c = 13; end
          2: begin a = 8; b = 15; c = 17; end
          default: begin a = 7; b = 24; c = 25; end
        endcase
        k = $urandom_range(1, 32767 / c);
        a *= k;
        b *= k;
        c *= k;
        if ($urandom_range(0, 1)) begin
          t = a;
          a = b;
          b = t;
        end
        x = $urandom_range(0, 1) ? -a : a;
        y = $urandom_range(0, 1) ? -b : b;
        z = $urandom_range(0, 1) ? -c : c;
      end
      9: begin
        x = 0;
        y = 0;
        z = $signed(16'($urandom));
      end
      default: begin
        x = $signed(16'($urandom));
        y = $signed(16'($urandom));
        z = $signed(16'($urandom));
      end
    endcase
    add_vector(x, y, z);
  endtask

  // Input driver, changes at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_taken) begin
        if (vectors_pending.size() > 0 && !take_gap()) begin
          in_data  <= vectors_pending.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= !take_gap();
    end
  end

  // Monitor: check results against the oldest expectation, record accepted vectors
  always @(posedge clk) begin
    out_item_t want;
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (angles_due.size() == 0) begin
          report_mismatch("unexpected result, pitch", out_data.pitch, 0);
        end else begin
          want = angles_due.pop_front();
          if (out_data.pitch !== want.pitch)
            report_mismatch("pitch", out_data.pitch, want.pitch);
          if (out_data.yaw !== want.yaw)
            report_mismatch("yaw", out_data.yaw, want.yaw);
        end
      end
      if (in_valid && in_ready) angles_due.push_back(predict_angles(in_data));
    end
  end

  // Cycle counter and timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int n;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    out_ready   = 1'b0;
    in_data     = '0;
    in_taken    = 1'b0;
    cycle_count = 0;
    mismatches  = 0;

    // Directed: extremes, straight up/down, axes, diagonals, exact 45 pitch
    add_vector(32767, 32767, 32767);
    add_vector(-32768, -32768, -32768);
    add_vector(0, 0, 0);
    add_vector(0, 0, 1);
    add_vector(0, 0, -1);
    add_vector(0, 0, 32767);
    add_vector(0, 0, -32768);
    add_vector(5, 0, 3);
    add_vector(-5, 0, 3);
    add_vector(0, 7, -2);
    add_vector(0, -7, 2);
    add_vector(100, 100, 0);
    add_vector(-100, 100, 9);
    add_vector(-100, -100, -9);
    add_vector(100, -100, 1);
    add_vector(3, 4, 5);
    add_vector(-3, 4, -5);
    add_vector(-32768, 0, -32768);
    add_vector(32767, 0, 32767);
    // Tiny negative angles truncate to zero, not 359
    add_vector(32767, -1, 0);
    add_vector(32767, 0, -1);
    add_vector(-32768, 1, 0);
    add_vector(-32768, -1, 0);
    add_vector(1, -32768, 32767);
    add_vector(-1, 32767, -32768);

    for (n = 0; n < RANDOM_ITEMS; n++) add_random_vector();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (vectors_pending.size() > 0 || in_valid || angles_due.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
